// File: sv/mcftq_pkg.sv
`timescale 1ns / 1ps
// mcftq_pkg: command and result types, operation and status codes, frame layout
// functions for the motor command frame transmit queue; no dependencies

package mcftq_pkg;

    // operation codes
    localparam logic [2:0] OP_ENABLE   = 3'd0;
    localparam logic [2:0] OP_SPEED    = 3'd1;
    localparam logic [2:0] OP_POSITION = 3'd2;
    localparam logic [2:0] OP_STOP     = 3'd3;
    localparam logic [2:0] OP_SYNC     = 3'd4;
    localparam logic [2:0] OP_POP      = 3'd5;

    // result status codes
    localparam logic [1:0] STS_QUEUED  = 2'd0;
    localparam logic [1:0] STS_DROPPED = 2'd1;
    localparam logic [1:0] STS_SENT    = 2'd2;
    localparam logic [1:0] STS_EMPTY   = 2'd3;

    // fixed frame bytes
    localparam logic [7:0] FRM_ENABLE_CMD = 8'hF3;
    localparam logic [7:0] FRM_ENABLE_SUB = 8'hAB;
    localparam logic [7:0] FRM_SPEED_CMD  = 8'hF6;
    localparam logic [7:0] FRM_POS_CMD    = 8'hFD;
    localparam logic [7:0] FRM_STOP_CMD   = 8'hFE;
    localparam logic [7:0] FRM_STOP_SUB   = 8'h98;
    localparam logic [7:0] FRM_SYNC_CMD   = 8'hFF;
    localparam logic [7:0] FRM_SYNC_SUB   = 8'h66;
    localparam logic [7:0] FRM_END        = 8'h6B;

    localparam int FREE_W = 9;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  motor_addr;
        logic [7:0]  enable_state;
        logic [7:0]  sync_flag;
        logic [7:0]  direction;
        logic [15:0] speed_rpm;
        logic [7:0]  accel;
        logic [31:0] pulse_count;
        logic [7:0]  relative_mode;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              tx_request;
        logic [FREE_W-1:0] free_space;
    } rsp_t;

    // frame length in bytes, zero for codes that build no frame
    function automatic logic [3:0] frame_len(input logic [2:0] op);
        logic [3:0] len;
        unique case (op)
            OP_ENABLE:   len = 4'd6;
            OP_SPEED:    len = 4'd8;
            OP_POSITION: len = 4'd13;
            OP_STOP:     len = 4'd5;
            OP_SYNC:     len = 4'd4;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    // byte at position idx of the frame built from c
    function automatic logic [7:0] frame_byte(input cmd_t c, input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 4'd0)
        begin
            b = c.motor_addr;
        end
        else
        begin
            unique case (c.operation)
                OP_ENABLE:
                begin
                    unique case (idx)
                        4'd1:    b = FRM_ENABLE_CMD;
                        4'd2:    b = FRM_ENABLE_SUB;
                        4'd3:    b = c.enable_state;
                        4'd4:    b = c.sync_flag;
                        default: b = FRM_END;
                    endcase
                end
                OP_SPEED:
                begin
                    unique case (idx)
                        4'd1:    b = FRM_SPEED_CMD;
                        4'd2:    b = c.direction;
                        4'd3:    b = c.speed_rpm[15:8];
                        4'd4:    b = c.speed_rpm[7:0];
                        4'd5:    b = c.accel;
                        4'd6:    b = c.sync_flag;
                        default: b = FRM_END;
                    endcase
                end
                OP_POSITION:
                begin
                    unique case (idx)
                        4'd1:    b = FRM_POS_CMD;
                        4'd2:    b = c.direction;
                        4'd3:    b = c.speed_rpm[15:8];
                        4'd4:    b = c.speed_rpm[7:0];
                        4'd5:    b = c.accel;
                        4'd6:    b = c.pulse_count[31:24];
                        4'd7:    b = c.pulse_count[23:16];
                        4'd8:    b = c.pulse_count[15:8];
                        4'd9:    b = c.pulse_count[7:0];
                        4'd10:   b = c.relative_mode;
                        4'd11:   b = c.sync_flag;
                        default: b = FRM_END;
                    endcase
                end
                OP_STOP:
                begin
                    unique case (idx)
                        4'd1:    b = FRM_STOP_CMD;
                        4'd2:    b = FRM_STOP_SUB;
                        4'd3:    b = c.sync_flag;
                        default: b = FRM_END;
                    endcase
                end
                OP_SYNC:
                begin
                    unique case (idx)
                        4'd1:    b = FRM_SYNC_CMD;
                        4'd2:    b = FRM_SYNC_SUB;
                        default: b = FRM_END;
                    endcase
                end
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// File: sv/mcftq_ram.sv
`timescale 1ns / 1ps
// mcftq_ram: generic single-write, single-read ram with registered read data
// no dependencies

module mcftq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/motor_command_frame_tx_queue.sv
`timescale 1ns / 1ps
// motor_command_frame_tx_queue: top level of the per-channel motor frame transmit queue
// depends on mcftq_pkg and mcftq_ram

// One instance serves one uart channel. A request is taken when start is high
// and busy is low. Command requests (enable, speed, position, stop, sync start)
// pack a frame of 4, 5, 6, 8 or 13 bytes and write it whole into the byte ring,
// or drop it whole when the free space is short. A pop request reads one byte
// for the transmitter, or reports empty and clears tx_request. Every request
// gives exactly one result, shown on result for the single cycle in which done
// is high; the receiver cannot hold it off, so it must sample it then.
// Timing: a queued frame of N bytes keeps busy high for its write sweep, one byte
// written per cycle through the ring ram's single write port, with done in the
// cycle after the last write. A pop with data passes through a read state because
// of the ram's registered read. A dropped frame, an empty pop
// or an undefined code finishes at the accepting edge, done in the next cycle,
// and busy stays low. No clearing pass after reset: only written bytes are read.

module motor_command_frame_tx_queue
    import mcftq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t command,
    output logic done,
    output rsp_t result
);

    // pointers run modulo twice the depth so full and empty differ
    localparam int PTR_MOD = 2 * QUEUE_DEPTH;
    localparam int PTR_W   = $clog2(PTR_MOD);
    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             req_reg, req_next;
    logic [3:0]       idx_reg, idx_next;
    logic [3:0]       len_reg, len_next;
    logic             done_reg, done_next;
    rsp_t             result_reg, result_next;
    cmd_t             cmd_reg;

    logic             accept;
    logic [3:0]       len_now;
    logic [CNT_W-1:0] used_now;
    logic [CNT_W-1:0] free_now;
    logic [CNT_W-1:0] free_after;
    logic [CNT_W+FREE_W-1:0] free_wide;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(PTR_MOD - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_addr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] a;
        if (p >= PTR_W'(QUEUE_DEPTH))
        begin
            a = p - PTR_W'(QUEUE_DEPTH);
        end
        else
        begin
            a = p;
        end
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] used_of(input logic [PTR_W-1:0] wr,
                                                 input logic [PTR_W-1:0] rd);
        logic [PTR_W:0] t;
        if (wr >= rd)
        begin
            t = {1'b0, wr} - {1'b0, rd};
        end
        else
        begin
            t = {1'b0, wr} + (PTR_W + 1)'(PTR_MOD) - {1'b0, rd};
        end
        return t[CNT_W-1:0];
    endfunction

    assign accept   = start && !busy;
    assign len_now  = frame_len(command.operation);
    assign used_now = used_of(wr_ptr_reg, rd_ptr_reg);
    assign free_now = CNT_W'(QUEUE_DEPTH) - used_now;

    // ring storage: frame bytes go in at the write pointer, pops read at the read pointer
    assign ram_waddr = ptr_addr(wr_ptr_reg);
    assign ram_raddr = ptr_addr(rd_ptr_reg);
    assign ram_wdata = frame_byte(cmd_reg, idx_reg);

    mcftq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next.tx_valid = 1'b0;
                    result_next.tx_byte  = 8'h00;
                    if (command.operation == OP_POP)
                    begin
                        if (used_now == '0)
                        begin
                            // nothing left to send: drop the transmit request
                            req_next           = 1'b0;
                            done_next          = 1'b1;
                            result_next.status = STS_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    else if ((len_now != 4'd0) && (free_now >= CNT_W'(len_now)))
                    begin
                        state_next = ST_WRITE;
                        idx_next   = 4'd0;
                        len_next   = len_now;
                    end
                    else
                    begin
                        // short space or an undefined code: nothing changes
                        done_next          = 1'b1;
                        result_next.status = STS_DROPPED;
                    end
                end
            end
            ST_WRITE:
            begin
                ram_we      = 1'b1;
                wr_ptr_next = ptr_inc(wr_ptr_reg);
                idx_next    = idx_reg + 4'd1;
                if (idx_reg == len_reg - 4'd1)
                begin
                    state_next         = ST_IDLE;
                    req_next           = 1'b1;
                    done_next          = 1'b1;
                    result_next.status = STS_QUEUED;
                end
            end
            ST_READ:
            begin
                rd_ptr_next          = ptr_inc(rd_ptr_reg);
                state_next           = ST_IDLE;
                done_next            = 1'b1;
                result_next.status   = STS_SENT;
                result_next.tx_valid = 1'b1;
                result_next.tx_byte  = ram_rdata;
            end
        endcase

        result_next.tx_request = req_next;
        result_next.free_space = free_wide[FREE_W-1:0];
    end

    // free space after this request, reported in its low bits
    assign free_after = CNT_W'(QUEUE_DEPTH) - used_of(wr_ptr_next, rd_ptr_next);
    assign free_wide  = (CNT_W + FREE_W)'(free_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            req_reg    <= 1'b0;
            idx_reg    <= 4'd0;
            len_reg    <= 4'd0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            req_reg    <= req_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    // command held for the frame write sweep
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in progress");

    a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_now <= CNT_W'(QUEUE_DEPTH))
        else $error("ring occupancy exceeds its depth");

    a_wr_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WRITE) |=> $stable(wr_ptr_reg))
        else $error("write pointer moved outside the frame write sweep");

    a_queued_sets_req: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STS_QUEUED)) |-> result.tx_request)
        else $error("queued frame without transmit request");

    a_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STS_EMPTY))
            |-> (!result.tx_valid && !result.tx_request
                 && (result.free_space == FREE_W'(QUEUE_DEPTH))))
        else $error("empty pop result inconsistent");
`endif

endmodule
